@@ sv/ogdi_pkg.sv @@
// ---------------------------------------------------------------------------
// ogdi_pkg
// Shared types and constants for the occupancy grid with disk inflation.
// ---------------------------------------------------------------------------
`default_nettype none

package ogdi_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MARK,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  // Command codes of an input word.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register byte addresses.
  localparam int unsigned PADDR_W = 5;
  localparam logic [PADDR_W-1:0] ADDR_GRID_WIDTH      = 5'h00;
  localparam logic [PADDR_W-1:0] ADDR_GRID_HEIGHT     = 5'h04;
  localparam logic [PADDR_W-1:0] ADDR_MARK_THRESHOLD  = 5'h08;
  localparam logic [PADDR_W-1:0] ADDR_INFLATION_REACH = 5'h0C;
  localparam logic [PADDR_W-1:0] ADDR_RADIUS_SQ_Q4    = 5'h10;

  // Register reset values.
  localparam logic [8:0]         RST_GRID_WIDTH      = 9'd256;
  localparam logic [8:0]         RST_GRID_HEIGHT     = 9'd256;
  localparam logic signed [7:0]  RST_MARK_THRESHOLD  = 8'sd100;
  localparam logic [3:0]         RST_INFLATION_REACH = 4'd0;
  localparam logic [11:0]        RST_RADIUS_SQ_Q4    = 12'd0;

endpackage

`default_nettype wire

@@ sv/occupancy_grid_disk_inflation.sv @@
// ---------------------------------------------------------------------------
// occupancy_grid_disk_inflation
// One-bit occupancy grid with threshold marking and disk-shaped inflation.
// ---------------------------------------------------------------------------
// Usage: command words enter on the in_valid/in_ready channel and every word
// returns exactly one result word (occupied, out_of_map) on the
// out_valid/out_ready channel. Settings are written through the APB port
// while the block is idle.
// The grid lives in a single-port-write, one-read memory of
// MAX_WIDTH*MAX_HEIGHT bits; the write port sets the pace. A mark with
// effective reach r sweeps (2r+1)^2 offsets, one offset a cycle, and writes
// those inside the map and the disk. A clear sweeps every entry. A read
// passes through READ and READ_WAIT; an out-of-map or below-threshold mark
// goes straight to the result.
// After reset the memory is cleared in a pass over all MAX_WIDTH*MAX_HEIGHT
// entries (65536 at the default size) with in_ready low; register writes are
// taken during that pass.
// Results go to an output register, so in_ready returns while a result still
// waits. When the receiver stalls, at most one further word is processed and
// held until the output register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_disk_inflation #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_REACH  = 15
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Command channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       command,
  input  wire logic [7:0]                       cell_x,
  input  wire logic [7:0]                       cell_y,
  input  wire logic signed [7:0]                cell_value,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  occupied,
  output logic                                  out_of_map,
  // Register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ogdi_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int MAXDIM0 = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAXDIM = (MAXDIM0 > 512) ? MAXDIM0 : 512;
  // Signed coordinate width: holds a cell index plus or minus the reach.
  localparam int CW     = $clog2(MAXDIM) + 2;
  // Signed offset width.
  localparam int RW     = $clog2(MAX_REACH + 1) + 1;
  localparam int SW     = 2 * (RW - 1);
  localparam int DW     = SW + 5;
  localparam int KW     = (DW > 12) ? DW : 12;

  // Registers of the APB port.
  logic [8:0]         grid_width;
  logic [8:0]         grid_height;
  logic signed [7:0]  mark_threshold;
  logic [3:0]         inflation_reach;
  logic [11:0]        radius_sq_q4;

  ogdi_pkg::state_t state, state_next;

  // Latched command.
  logic [7:0]           x_r;
  logic [7:0]           y_r;
  logic signed [RW-1:0] reach_r;
  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;
  logic                 res_occ;
  logic                 res_oom;
  logic [AW-1:0]        clr_addr;

  // Memory and its ports.
  logic                 mem [0:DEPTH-1];
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 wr_data;
  logic [AW-1:0]        rd_addr;
  logic                 rd_data;

  // Control strobes from the state decoder.
  logic accept;
  logic clr_step;
  logic walk_step;
  logic cap_read;
  logic load_out;

  logic signed [CW-1:0] lim_w;
  logic signed [CW-1:0] lim_h;
  logic                 in_map_in;
  logic                 meets_thr;
  logic signed [RW-1:0] eff_reach;
  logic                 walk_last;
  logic                 clr_last;

  logic signed [CW-1:0] tx;
  logic signed [CW-1:0] ty;
  logic signed [RW-1:0] abs_x;
  logic signed [RW-1:0] abs_y;
  logic [SW-1:0]        sq_x;
  logic [SW-1:0]        sq_y;
  logic [SW:0]          d2;
  logic                 dist_ok;
  logic                 cand_in_map;
  logic                 cand_set;
  logic [AW-1:0]        cand_addr;

  // ---------------- register port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= ogdi_pkg::RST_GRID_WIDTH;
      grid_height     <= ogdi_pkg::RST_GRID_HEIGHT;
      mark_threshold  <= ogdi_pkg::RST_MARK_THRESHOLD;
      inflation_reach <= ogdi_pkg::RST_INFLATION_REACH;
      radius_sq_q4    <= ogdi_pkg::RST_RADIUS_SQ_Q4;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr)
        ogdi_pkg::ADDR_GRID_WIDTH:      grid_width      <= pwdata[8:0];
        ogdi_pkg::ADDR_GRID_HEIGHT:     grid_height     <= pwdata[8:0];
        ogdi_pkg::ADDR_MARK_THRESHOLD:  mark_threshold  <= pwdata[7:0];
        ogdi_pkg::ADDR_INFLATION_REACH: inflation_reach <= pwdata[3:0];
        ogdi_pkg::ADDR_RADIUS_SQ_Q4:    radius_sq_q4    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ogdi_pkg::ADDR_GRID_WIDTH:      prdata = {23'd0, grid_width};
      ogdi_pkg::ADDR_GRID_HEIGHT:     prdata = {23'd0, grid_height};
      ogdi_pkg::ADDR_MARK_THRESHOLD:  prdata = {24'd0, mark_threshold};
      ogdi_pkg::ADDR_INFLATION_REACH: prdata = {28'd0, inflation_reach};
      ogdi_pkg::ADDR_RADIUS_SQ_Q4:    prdata = {20'd0, radius_sq_q4};
      default:                        prdata = 32'd0;
    endcase
  end

  // ---------------- decisions on the incoming word ----------------
  // Sizes above the store are clamped to its dimensions.
  assign lim_w = (CW'(grid_width) < CW'(MAX_WIDTH)) ? CW'(grid_width) : CW'(MAX_WIDTH);
  assign lim_h = (CW'(grid_height) < CW'(MAX_HEIGHT)) ? CW'(grid_height) : CW'(MAX_HEIGHT);

  assign in_map_in = ($signed(CW'(cell_x)) < lim_w) && ($signed(CW'(cell_y)) < lim_h);
  assign meets_thr = (cell_value >= mark_threshold);
  assign eff_reach = (32'(inflation_reach) > 32'(MAX_REACH)) ? RW'(MAX_REACH)
                                                              : RW'(inflation_reach);

  assign accept    = in_valid && in_ready;
  assign walk_last = (dx == reach_r) && (dy == reach_r);
  assign clr_last  = (clr_addr == AW'(DEPTH - 1));

  // ---------------- inflation candidate ----------------
  assign tx = $signed(CW'(x_r)) + CW'(dx);
  assign ty = $signed(CW'(y_r)) + CW'(dy);

  assign abs_x = dx[RW-1] ? -dx : dx;
  assign abs_y = dy[RW-1] ? -dy : dy;
  assign sq_x  = SW'(abs_x[RW-2:0]) * SW'(abs_x[RW-2:0]);
  assign sq_y  = SW'(abs_y[RW-2:0]) * SW'(abs_y[RW-2:0]);
  assign d2    = (SW+1)'(sq_x) + (SW+1)'(sq_y);
  // Distance between cell centres, squared, in sixteenths of a cell squared.
  assign dist_ok = (KW'({d2, 4'b0000}) <= KW'(radius_sq_q4));

  assign cand_in_map = !tx[CW-1] && !ty[CW-1] && (tx < lim_w) && (ty < lim_h);
  assign cand_set    = cand_in_map && dist_ok;
  assign cand_addr   = AW'($unsigned(ty)) * AW'(MAX_WIDTH) + AW'($unsigned(tx));

  assign rd_addr     = AW'(y_r) * AW'(MAX_WIDTH) + AW'(x_r);

  // ---------------- state machine ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ogdi_pkg::ST_INIT: begin
        if (clr_last) state_next = ogdi_pkg::ST_IDLE;
      end
      ogdi_pkg::ST_IDLE: begin
        if (accept) begin
          case (command)
            ogdi_pkg::CMD_CLEAR: state_next = ogdi_pkg::ST_CLEAR;
            ogdi_pkg::CMD_MARK: begin
              if (in_map_in && meets_thr) state_next = ogdi_pkg::ST_MARK;
              else state_next = ogdi_pkg::ST_RESULT;
            end
            ogdi_pkg::CMD_READ: begin
              if (in_map_in) state_next = ogdi_pkg::ST_READ;
              else state_next = ogdi_pkg::ST_RESULT;
            end
            default: state_next = ogdi_pkg::ST_RESULT;
          endcase
        end
      end
      ogdi_pkg::ST_CLEAR: begin
        if (clr_last) state_next = ogdi_pkg::ST_RESULT;
      end
      ogdi_pkg::ST_MARK: begin
        if (walk_last) state_next = ogdi_pkg::ST_RESULT;
      end
      ogdi_pkg::ST_READ:      state_next = ogdi_pkg::ST_READ_WAIT;
      ogdi_pkg::ST_READ_WAIT: state_next = ogdi_pkg::ST_RESULT;
      ogdi_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) state_next = ogdi_pkg::ST_IDLE;
      end
      default: state_next = ogdi_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    clr_step  = 1'b0;
    walk_step = 1'b0;
    cap_read  = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ogdi_pkg::ST_INIT:      clr_step  = 1'b1;
      ogdi_pkg::ST_IDLE:      in_ready  = 1'b1;
      ogdi_pkg::ST_CLEAR:     clr_step  = 1'b1;
      ogdi_pkg::ST_MARK:      walk_step = 1'b1;
      ogdi_pkg::ST_READ:      ;
      ogdi_pkg::ST_READ_WAIT: cap_read  = 1'b1;
      ogdi_pkg::ST_RESULT:    load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ogdi_pkg::ST_INIT;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clr_step) clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
    end
  end

  // ---------------- command datapath ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= cell_x;
      y_r     <= cell_y;
      reach_r <= eff_reach;
      dx      <= -eff_reach;
      dy      <= -eff_reach;
      case (command)
        ogdi_pkg::CMD_MARK: begin
          res_oom <= !in_map_in;
          res_occ <= in_map_in && meets_thr;
        end
        ogdi_pkg::CMD_READ: begin
          res_oom <= !in_map_in;
          res_occ <= 1'b0;
        end
        default: begin
          res_oom <= 1'b0;
          res_occ <= 1'b0;
        end
      endcase
    end else if (walk_step) begin
      if (dy == reach_r) begin
        dy <= -reach_r;
        dx <= dx + RW'(1);
      end else begin
        dy <= dy + RW'(1);
      end
    end else if (cap_read) begin
      res_occ <= rd_data;
    end
  end

  // ---------------- grid memory ----------------
  // The write port is registered; the clear sweep and the inflation walk share it.
  always_ff @(posedge clk) begin
    if (rst) wr_en <= 1'b0;
    else     wr_en <= clr_step || (walk_step && cand_set);
  end

  always_ff @(posedge clk) begin
    wr_addr <= clr_step ? clr_addr : cand_addr;
    wr_data <= !clr_step;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      occupied   <= res_occ;
      out_of_map <= res_oom;
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the occupancy grid with disk inflation against a cycle-free
// predictor: mark, read, clear and unused command words on valid/ready
// channels, register settings through the APB port, random idle and stall.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int GRID_SIDE   = 256;
  localparam int REACH_LIMIT = 15;

  typedef struct packed {
    logic occupied;
    logic out_of_map;
  } cell_status_t;

  // Tracks the grid contents and register values, and holds the status
  // words still owed by the block in order of acceptance.
  class occupancy_tracker;
    bit [GRID_SIDE*GRID_SIDE-1:0] cells;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic signed [7:0] threshold_reg;
    logic [3:0] reach_reg;
    logic [11:0] radius_reg;
    cell_status_t owed_status[$];
    int errors = 0;

    function void reset_state();
      cells = '0;
      width_reg = ogdi_pkg::RST_GRID_WIDTH;
      height_reg = ogdi_pkg::RST_GRID_HEIGHT;
      threshold_reg = ogdi_pkg::RST_MARK_THRESHOLD;
      reach_reg = ogdi_pkg::RST_INFLATION_REACH;
      radius_reg = ogdi_pkg::RST_RADIUS_SQ_Q4;
    endfunction

    function int map_width();
      return (width_reg > GRID_SIDE) ? GRID_SIDE : int'(width_reg);
    endfunction

    function int map_height();
      return (height_reg > GRID_SIDE) ? GRID_SIDE : int'(height_reg);
    endfunction

    function bit in_map(int x, int y);
      return x >= 0 && y >= 0 && x < map_width() && y < map_height();
    endfunction

    function int outstanding();
      return owed_status.size();
    endfunction

    function void set_reg(logic [ogdi_pkg::PADDR_W-1:0] addr, logic [31:0] data);
      case (addr)
        ogdi_pkg::ADDR_GRID_WIDTH:      width_reg = data[8:0];
        ogdi_pkg::ADDR_GRID_HEIGHT:     height_reg = data[8:0];
        ogdi_pkg::ADDR_MARK_THRESHOLD:  threshold_reg = data[7:0];
        ogdi_pkg::ADDR_INFLATION_REACH: reach_reg = data[3:0];
        ogdi_pkg::ADDR_RADIUS_SQ_Q4:    radius_reg = data[11:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                            logic signed [7:0] value);
      cell_status_t res;
      int cx;
      int cy;
      int r;
      res = '0;
      cx = x;
      cy = y;
      case (cmd)
        ogdi_pkg::CMD_CLEAR: cells = '0;
        ogdi_pkg::CMD_MARK: begin
          if (!in_map(cx, cy)) begin
            res.out_of_map = 1'b1;
          end else if (value >= threshold_reg) begin
            r = (reach_reg > REACH_LIMIT) ? REACH_LIMIT : int'(reach_reg);
            cells[cy*GRID_SIDE + cx] = 1'b1;
            // Disk test between cell centres, in sixteenths of a cell squared.
            for (int dx = -r; dx <= r; dx++) begin
              for (int dy = -r; dy <= r; dy++) begin
                if (in_map(cx + dx, cy + dy) && 16*(dx*dx + dy*dy) <= int'(radius_reg))
                  cells[(cy + dy)*GRID_SIDE + cx + dx] = 1'b1;
              end
            end
            res.occupied = 1'b1;
          end
        end
        ogdi_pkg::CMD_READ: begin
          if (!in_map(cx, cy))
            res.out_of_map = 1'b1;
          else
            res.occupied = cells[cy*GRID_SIDE + cx];
        end
        default: ;
      endcase
      owed_status.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic occ, logic oom);
      cell_status_t want;
      if (owed_status.size() == 0) begin
        report($sformatf("word with no request pending: occupied=%0b out_of_map=%0b",
                         occ, oom));
        return;
      end
      want = owed_status.pop_front();
      if (occ !== want.occupied)
        report($sformatf("occupied is %0b, predicted %0b", occ, want.occupied));
      if (oom !== want.out_of_map)
        report($sformatf("out_of_map is %0b, predicted %0b", oom, want.out_of_map));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = ogdi_pkg::CMD_CLEAR;
  logic [7:0] cell_x = '0;
  logic [7:0] cell_y = '0;
  logic signed [7:0] cell_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic occupied;
  logic out_of_map;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ogdi_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int send_idle_pct = 0;
  int stall_pct = 0;
  occupancy_tracker grid;

  occupancy_grid_disk_inflation u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .occupied   (occupied),
    .out_of_map (out_of_map),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("occupancy_grid_disk_inflation regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      grid.check_result(occupied, out_of_map);
  end

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic send_word(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                           logic signed [7:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    cell_x <= x;
    cell_y <= y;
    cell_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grid.note_word(cmd, x, y, value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grid.outstanding() != 0) @(posedge clk);
  endtask

  // Back-to-back writes go straight from access to the next setup phase.
  task automatic apb_write(logic [ogdi_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    grid.set_reg(addr, data);
  endtask

  task automatic set_config(logic [8:0] w, logic [8:0] h, logic signed [7:0] thr,
                            logic [3:0] reach, logic [11:0] rad);
    apb_write(ogdi_pkg::ADDR_GRID_WIDTH, {23'd0, w});
    apb_write(ogdi_pkg::ADDR_GRID_HEIGHT, {23'd0, h});
    apb_write(ogdi_pkg::ADDR_MARK_THRESHOLD, {24'd0, thr});
    apb_write(ogdi_pkg::ADDR_INFLATION_REACH, {28'd0, reach});
    apb_write(ogdi_pkg::ADDR_RADIUS_SQ_Q4, {20'd0, rad});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 9'($urandom_range(1, 16));
      1: return 9'($urandom_range(1, 256));
      2: return 9'd256;
      default: return 9'($urandom_range(257, 511));
    endcase
  endfunction

  task automatic run_phase(int phase, int n_words);
    logic [8:0] w;
    logic [8:0] h;
    logic signed [7:0] thr;
    logic [3:0] reach;
    logic [11:0] rad;
    logic [1:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic signed [7:0] value;
    int r;
    int tv;
    int mw;
    int mh;
    int clear_at;
    int last_x;
    int last_y;
    bit have_mark;
    case (phase)
      0: begin w = 256; h = 256; thr = 0;    reach = 1;  rad = 16;   end
      1: begin w = 1;   h = 1;   thr = -128; reach = 15; rad = 4095; end
      2: begin w = 511; h = 300; thr = 127;  reach = 15; rad = 4095; end
      3: begin w = 2;   h = 256; thr = 50;   reach = 3;  rad = 0;    end
      default: begin
        w = pick_size();
        h = pick_size();
        if ($urandom_range(0, 1))
          thr = 8'($urandom_range(0, 255));
        else
          thr = 8'(int'($urandom_range(0, 101)) - 1);
        reach = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) begin
          rad = 12'($urandom_range(0, 4095));
        end else begin
          tv = 16 * int'($urandom_range(0, 2*int'(reach)*int'(reach)));
          rad = 12'((tv > 4095) ? 4095 : tv);
        end
      end
    endcase
    set_config(w, h, thr, reach, rad);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 81; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 81; end
      default: begin send_idle_pct = 25; stall_pct = 25; end
    endcase
    // A clear sweeps the whole store, so only a few phases carry one.
    clear_at = (phase % 4 == 3) ? int'($urandom_range(0, n_words - 1)) : -1;
    have_mark = 1'b0;
    last_x = 0;
    last_y = 0;
    mw = grid.map_width();
    mh = grid.map_height();
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (i == clear_at) cmd = ogdi_pkg::CMD_CLEAR;
      else if (r < 3) cmd = CMD_UNUSED;
      else if (r < 50) cmd = ogdi_pkg::CMD_READ;
      else cmd = ogdi_pkg::CMD_MARK;
      if (cmd == ogdi_pkg::CMD_READ && have_mark && $urandom_range(0, 1)) begin
        // Read around the latest mark to land on the inflated disk and its rim.
        tv = last_x + int'($urandom_range(0, 2*int'(reach) + 2)) - int'(reach) - 1;
        x = 8'((tv < 0) ? 0 : (tv > 255) ? 255 : tv);
        tv = last_y + int'($urandom_range(0, 2*int'(reach) + 2)) - int'(reach) - 1;
        y = 8'((tv < 0) ? 0 : (tv > 255) ? 255 : tv);
      end else if (mw > 0 && mh > 0 && $urandom_range(0, 99) < 85) begin
        x = 8'($urandom_range(0, mw - 1));
        y = 8'($urandom_range(0, mh - 1));
      end else begin
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 1)) begin
        tv = int'(grid.threshold_reg) + int'($urandom_range(0, 4)) - 2;
        value = 8'((tv > 127) ? 127 : (tv < -128) ? -128 : tv);
      end else begin
        value = 8'($urandom_range(0, 255));
      end
      if (cmd == ogdi_pkg::CMD_MARK) begin
        last_x = x;
        last_y = y;
        have_mark = 1'b1;
      end
      send_word(cmd, x, y, value);
    end
    drain();
  endtask

  initial begin
    grid = new();
    grid.reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full 256 x 256 map, threshold 100, no inflation.
    send_word(ogdi_pkg::CMD_READ, 0, 0, 0);
    send_word(ogdi_pkg::CMD_READ, 255, 255, 0);
    send_word(ogdi_pkg::CMD_MARK, 255, 255, 127);
    send_word(ogdi_pkg::CMD_MARK, 0, 0, -128);
    send_word(ogdi_pkg::CMD_MARK, 10, 10, 100);
    send_word(ogdi_pkg::CMD_MARK, 11, 10, 99);
    send_word(ogdi_pkg::CMD_READ, 10, 10, 0);
    send_word(ogdi_pkg::CMD_READ, 11, 10, 0);
    send_word(ogdi_pkg::CMD_READ, 255, 255, 0);
    send_word(CMD_UNUSED, 255, 255, 127);
    send_word(ogdi_pkg::CMD_CLEAR, 0, 0, 0);
    send_word(ogdi_pkg::CMD_READ, 10, 10, 0);
    drain();

    // Tiny map with the widest disk: one mark fills it.
    set_config(5, 3, -128, 15, 4095);
    send_word(ogdi_pkg::CMD_MARK, 2, 1, -128);
    send_word(ogdi_pkg::CMD_READ, 4, 2, 0);
    send_word(ogdi_pkg::CMD_READ, 0, 0, 0);
    send_word(ogdi_pkg::CMD_MARK, 5, 0, 0);
    send_word(ogdi_pkg::CMD_READ, 0, 3, 0);
    send_word(ogdi_pkg::CMD_READ, 255, 255, 0);
    drain();

    // Zero width puts every cell out of the map.
    set_config(0, 511, 100, 2, 36);
    send_word(ogdi_pkg::CMD_MARK, 0, 0, 127);
    send_word(ogdi_pkg::CMD_READ, 0, 0, 0);
    drain();

    // Oversized settings clamp to the store; earlier bits survive the resize.
    set_config(511, 511, 100, 15, 0);
    send_word(ogdi_pkg::CMD_READ, 4, 2, 0);
    send_word(ogdi_pkg::CMD_READ, 255, 255, 0);
    send_word(ogdi_pkg::CMD_MARK, 128, 128, 127);
    send_word(ogdi_pkg::CMD_READ, 129, 128, 0);
    send_word(ogdi_pkg::CMD_READ, 128, 128, 0);
    drain();

    for (int p = 0; p < 12; p++)
      run_phase(p, 50);

    send_idle_pct = 0;
    stall_pct = 0;
    // Idle a while so that a stray extra word would still be caught.
    repeat (1000) @(posedge clk);
    if (grid.errors == 0)
      $display("occupancy_grid_disk_inflation regression: pass");
    else
      $display("occupancy_grid_disk_inflation regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/ogdi_pkg.sv
sv/occupancy_grid_disk_inflation.sv
dv/testbench.sv
